@@ rtl/phj_pkg.sv @@
// shared types and constants of the pinhole projection unit
// used by phj_div, phj_mul and the top level; no dependencies
`default_nettype none
package phj_pkg;

    // side information that travels with an item through the divider
    typedef struct packed {
        logic neg_x;
        logic neg_y;
        logic zbad;
    } t_tag;

    // configuration register indexes
    localparam logic [1:0] CFG_FOCAL_X  = 2'd0;
    localparam logic [1:0] CFG_FOCAL_Y  = 2'd1;
    localparam logic [1:0] CFG_CENTER_X = 2'd2;
    localparam logic [1:0] CFG_CENTER_Y = 2'd3;

    // divider lanes
    localparam int LANE_IZ = 0;
    localparam int LANE_XN = 1;
    localparam int LANE_YN = 2;
    localparam int NLANE   = 3;

    // positions of the values of one result row
    localparam int J_PIX = 0;
    localparam int J_TX  = 1;
    localparam int J_TY  = 2;
    localparam int J_TZ  = 3;
    localparam int J_RX  = 4;
    localparam int J_RY  = 5;
    localparam int J_RZ  = 6;
    localparam int NJ    = 7;

endpackage
`default_nettype wire

@@ rtl/phj_div.sv @@
// pipelined restoring divider, one quotient bit per stage, three lanes sharing one divisor
// depends on phj_pkg for the item tag
`default_nettype none
module phj_div #(
    parameter int CW = 32,
    parameter int FB = 16,
    localparam int NW = (CW + FB > 2 * FB + 1) ? CW + FB : 2 * FB + 1
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic          i_valid,
    input  wire phj_pkg::t_tag i_tag,
    input  wire logic [CW-2:0] i_den,
    input  wire logic [CW-1:0] i_mag_x,
    input  wire logic [CW-1:0] i_mag_y,
    output logic               o_valid,
    output phj_pkg::t_tag      o_tag,
    output logic [CW-2:0]      o_den,
    output logic [NW-1:0]      o_quo [phj_pkg::NLANE],
    output logic [CW-2:0]      o_rem [phj_pkg::NLANE]
);

    logic [NW:0]          r_v;
    phj_pkg::t_tag        r_tag [0:NW];
    logic [CW-2:0]        r_d   [0:NW];
    logic [NW-1:0]        r_w   [0:NW][phj_pkg::NLANE];
    logic [CW-2:0]        r_r   [0:NW][phj_pkg::NLANE];
    logic [NW-1:0]        n_w   [0:NW-1][phj_pkg::NLANE];
    logic [CW-2:0]        n_r   [0:NW-1][phj_pkg::NLANE];
    logic [NW-1:0]        num   [phj_pkg::NLANE];

    always_comb begin
        num[phj_pkg::LANE_IZ] = NW'(1) << (2 * FB);
        num[phj_pkg::LANE_XN] = NW'(i_mag_x) << FB;
        num[phj_pkg::LANE_YN] = NW'(i_mag_y) << FB;
    end

    // remainder shifts in the next numerator bit, quotient bit enters at the bottom
    always_comb begin
        logic [CW-1:0] t;
        logic          ge;
        for (int k = 0; k < NW; k++) begin
            for (int l = 0; l < phj_pkg::NLANE; l++) begin
                t  = {r_r[k][l], r_w[k][l][NW-1]};
                ge = (t >= {1'b0, r_d[k]});
                n_r[k][l] = ge ? (CW - 1)'(t - {1'b0, r_d[k]}) : t[CW-2:0];
                n_w[k][l] = {r_w[k][l][NW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[NW-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag[0] <= i_tag;
            r_d[0]   <= i_den;
            for (int l = 0; l < phj_pkg::NLANE; l++) begin
                r_w[0][l] <= num[l];
                r_r[0][l] <= '0;
            end
            for (int k = 0; k < NW; k++) begin
                r_tag[k+1] <= r_tag[k];
                r_d[k+1]   <= r_d[k];
                for (int l = 0; l < phj_pkg::NLANE; l++) begin
                    r_w[k+1][l] <= n_w[k][l];
                    r_r[k+1][l] <= n_r[k][l];
                end
            end
        end
    end

    assign o_valid = r_v[NW];
    assign o_tag   = r_tag[NW];
    assign o_den   = r_d[NW];
    always_comb begin
        for (int l = 0; l < phj_pkg::NLANE; l++) begin
            o_quo[l] = r_w[NW][l];
            o_rem[l] = r_r[NW][l];
        end
    end

endmodule
`default_nettype wire

@@ rtl/phj_mul.sv @@
// quotient rounding, products, product rounding and final sums with saturation
// four register stages; depends on phj_pkg
`default_nettype none
module phj_mul #(
    parameter int CW = 32,
    parameter int FB = 16,
    localparam int NW = (CW + FB > 2 * FB + 1) ? CW + FB : 2 * FB + 1
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_en,
    input  wire logic               i_valid,
    input  wire phj_pkg::t_tag      i_tag,
    input  wire logic [CW-2:0]      i_den,
    input  wire logic [NW-1:0]      i_quo [phj_pkg::NLANE],
    input  wire logic [CW-2:0]      i_rem [phj_pkg::NLANE],
    input  wire logic [CW-2:0]      i_focal_x,
    input  wire logic [CW-2:0]      i_focal_y,
    input  wire logic signed [CW-1:0] i_center_x,
    input  wire logic signed [CW-1:0] i_center_y,
    output logic                    o_valid,
    output logic [CW-1:0]           o_row0 [phj_pkg::NJ],
    output logic [CW-1:0]           o_row1 [phj_pkg::NJ],
    output logic                    o_bad0,
    output logic                    o_bad1
);

    localparam int RW = 2 * CW - FB;
    localparam int EW = ((RW + 1 > CW) ? RW + 1 : CW) + 2;
    localparam logic [NW:0] HALF_Q = (NW + 1)'(1) << (CW - 1);
    localparam logic [2*CW-1:0] HALF_P = (2 * CW)'(1) << (FB - 1);
    localparam logic signed [EW-1:0] SMAX_E = (EW'(1) << (CW - 1)) - EW'(1);
    localparam logic signed [EW-1:0] SMIN_E = -(EW'(1) << (CW - 1));
    localparam logic signed [EW-1:0] ONE_E = EW'(1) << FB;

    // product slots
    localparam int P_XF = 0;
    localparam int P_YF = 1;
    localparam int P_XI = 2;
    localparam int P_YI = 3;
    localparam int P_XY = 4;
    localparam int P_XX = 5;
    localparam int P_YY = 6;
    localparam int NP   = 7;

    function automatic logic [CW:0] sat(input logic signed [EW-1:0] v);
        logic [CW:0] res;
        if (v > SMAX_E) begin
            res = {1'b1, SMAX_E[CW-1:0]};
        end else if (v < SMIN_E) begin
            res = {1'b1, SMIN_E[CW-1:0]};
        end else begin
            res = {1'b0, v[CW-1:0]};
        end
        return res;
    endfunction

    logic [3:0] r_v;

    // stage 1: rounded, clamped quotients
    logic [CW-1:0]        r1_m [phj_pkg::NLANE];
    logic                 r1_n [phj_pkg::NLANE];
    logic signed [CW-1:0] r1_s [phj_pkg::NLANE];
    logic                 r1_sh, r1_zbad;
    logic [CW-1:0]        n1_m [phj_pkg::NLANE];
    logic                 n1_n [phj_pkg::NLANE];
    logic signed [CW-1:0] n1_s [phj_pkg::NLANE];
    logic                 n1_sh;

    always_comb begin
        logic [NW:0] q;
        logic [NW:0] lim;
        logic        over;
        n1_n[phj_pkg::LANE_IZ] = 1'b0;
        n1_n[phj_pkg::LANE_XN] = i_tag.neg_x;
        n1_n[phj_pkg::LANE_YN] = i_tag.neg_y;
        n1_sh = 1'b0;
        for (int l = 0; l < phj_pkg::NLANE; l++) begin
            // round to nearest, ties away: twice the remainder against the divisor
            q    = {1'b0, i_quo[l]} + (NW + 1)'({i_rem[l], 1'b0} >= {1'b0, i_den});
            lim  = n1_n[l] ? HALF_Q : HALF_Q - (NW + 1)'(1);
            over = (q > lim);
            n1_m[l] = over ? lim[CW-1:0] : q[CW-1:0];
            n1_s[l] = n1_n[l] ? -n1_m[l] : n1_m[l];
            n1_sh   = n1_sh | over;
        end
    end

    // stage 2: magnitude products
    logic [2*CW-1:0]      r2_p [NP];
    logic                 r2_n [NP];
    logic signed [CW-1:0] r2_s [phj_pkg::NLANE];
    logic                 r2_sh, r2_zbad;

    // stage 3: rounded signed products
    logic signed [RW:0]   r3_q [NP];
    logic signed [CW-1:0] r3_s [phj_pkg::NLANE];
    logic                 r3_sh, r3_zbad;
    logic signed [RW:0]   n3_q [NP];

    always_comb begin
        logic [2*CW-1:0] t;
        for (int p = 0; p < NP; p++) begin
            t = r2_p[p] + HALF_P;
            n3_q[p] = r2_n[p] ? -$signed({1'b0, t[2*CW-1:FB]})
                              : $signed({1'b0, t[2*CW-1:FB]});
        end
    end

    // stage 4: final row values
    logic [CW-1:0] n4_row0 [phj_pkg::NJ];
    logic [CW-1:0] n4_row1 [phj_pkg::NJ];
    logic          n4_bad0, n4_bad1;

    always_comb begin
        logic signed [EW-1:0] e [NP];
        logic signed [EW-1:0] iz, xn, yn;
        logic [CW:0]          s0 [phj_pkg::NJ];
        logic [CW:0]          s1 [phj_pkg::NJ];
        for (int p = 0; p < NP; p++) begin
            e[p] = EW'(r3_q[p]);
        end
        iz = EW'(r3_s[phj_pkg::LANE_IZ]);
        xn = EW'(r3_s[phj_pkg::LANE_XN]);
        yn = EW'(r3_s[phj_pkg::LANE_YN]);
        s0[phj_pkg::J_PIX] = sat(e[P_XF] + EW'(i_center_x));
        s0[phj_pkg::J_TX]  = sat(iz);
        s0[phj_pkg::J_TY]  = '0;
        s0[phj_pkg::J_TZ]  = sat(-e[P_XI]);
        s0[phj_pkg::J_RX]  = sat(-e[P_XY]);
        s0[phj_pkg::J_RY]  = sat(ONE_E + e[P_XX]);
        s0[phj_pkg::J_RZ]  = sat(-yn);
        s1[phj_pkg::J_PIX] = sat(e[P_YF] + EW'(i_center_y));
        s1[phj_pkg::J_TX]  = '0;
        s1[phj_pkg::J_TY]  = sat(iz);
        s1[phj_pkg::J_TZ]  = sat(-e[P_YI]);
        s1[phj_pkg::J_RX]  = sat(-(ONE_E + e[P_YY]));
        s1[phj_pkg::J_RY]  = sat(e[P_XY]);
        s1[phj_pkg::J_RZ]  = sat(xn);
        n4_bad0 = r3_sh | r3_zbad;
        n4_bad1 = r3_sh | r3_zbad;
        for (int j = 0; j < phj_pkg::NJ; j++) begin
            n4_bad0 = n4_bad0 | s0[j][CW];
            n4_bad1 = n4_bad1 | s1[j][CW];
            // non-positive depth gives all-zero rows
            n4_row0[j] = r3_zbad ? '0 : s0[j][CW-1:0];
            n4_row1[j] = r3_zbad ? '0 : s1[j][CW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_m    <= n1_m;
            r1_n    <= n1_n;
            r1_s    <= n1_s;
            r1_sh   <= n1_sh;
            r1_zbad <= i_tag.zbad;

            r2_p[P_XF] <= (2 * CW)'(r1_m[phj_pkg::LANE_XN]) * (2 * CW)'({1'b0, i_focal_x});
            r2_p[P_YF] <= (2 * CW)'(r1_m[phj_pkg::LANE_YN]) * (2 * CW)'({1'b0, i_focal_y});
            r2_p[P_XI] <= (2 * CW)'(r1_m[phj_pkg::LANE_XN])
                          * (2 * CW)'(r1_m[phj_pkg::LANE_IZ]);
            r2_p[P_YI] <= (2 * CW)'(r1_m[phj_pkg::LANE_YN])
                          * (2 * CW)'(r1_m[phj_pkg::LANE_IZ]);
            r2_p[P_XY] <= (2 * CW)'(r1_m[phj_pkg::LANE_XN])
                          * (2 * CW)'(r1_m[phj_pkg::LANE_YN]);
            r2_p[P_XX] <= (2 * CW)'(r1_m[phj_pkg::LANE_XN])
                          * (2 * CW)'(r1_m[phj_pkg::LANE_XN]);
            r2_p[P_YY] <= (2 * CW)'(r1_m[phj_pkg::LANE_YN])
                          * (2 * CW)'(r1_m[phj_pkg::LANE_YN]);
            r2_n[P_XF] <= r1_n[phj_pkg::LANE_XN];
            r2_n[P_YF] <= r1_n[phj_pkg::LANE_YN];
            r2_n[P_XI] <= r1_n[phj_pkg::LANE_XN];
            r2_n[P_YI] <= r1_n[phj_pkg::LANE_YN];
            r2_n[P_XY] <= r1_n[phj_pkg::LANE_XN] ^ r1_n[phj_pkg::LANE_YN];
            r2_n[P_XX] <= 1'b0;
            r2_n[P_YY] <= 1'b0;
            r2_s    <= r1_s;
            r2_sh   <= r1_sh;
            r2_zbad <= r1_zbad;

            r3_q    <= n3_q;
            r3_s    <= r2_s;
            r3_sh   <= r2_sh;
            r3_zbad <= r2_zbad;

            o_row0 <= n4_row0;
            o_row1 <= n4_row1;
            o_bad0 <= n4_bad0;
            o_bad1 <= n4_bad1;
        end
    end

    assign o_valid = r_v[3];

endmodule
`default_nettype wire

@@ rtl/pinhole_projection_with_jacobian_unit.sv @@
// top level of the pinhole projection unit: config registers, divider, product pipeline
// and the two-row output sequencer; depends on phj_pkg, phj_div and phj_mul
`default_nettype none
// Each accepted point (x, y, z) yields two result items: the u row (row_index 0) and the
// v row (row_index 1, last set), each with the pixel coordinate and six pose Jacobian
// entries. The pipeline is CW+FB+1 (or 2*FB+2 if larger) divider register stages plus four
// stages of rounding, multiplication and saturation; the u row is presented once the point
// has passed all of them, and the v row in the cycle after the u row is taken. Each point
// sends two result items through the single output port, so the pipeline holds while a
// finished point waits at the output until its v row is taken; the pipeline itself takes
// a point in every cycle while the output stage is free. Configuration must be written
// only while the unit is idle; the unit itself does not enforce this.
module pinhole_projection_with_jacobian_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [1:0]             i_cfg_idx,
    input  wire logic [COORD_WIDTH-1:0] i_cfg_data,
    input  wire logic                   i_valid,
    output logic                        o_stall,
    input  wire logic [COORD_WIDTH-1:0] i_point_x,
    input  wire logic [COORD_WIDTH-1:0] i_point_y,
    input  wire logic [COORD_WIDTH-1:0] i_point_z,
    output logic                        o_valid,
    input  wire logic                   i_stall,
    output logic                        o_row_index,
    output logic [COORD_WIDTH-1:0]      o_pixel_coord,
    output logic [COORD_WIDTH-1:0]      o_jac_tx,
    output logic [COORD_WIDTH-1:0]      o_jac_ty,
    output logic [COORD_WIDTH-1:0]      o_jac_tz,
    output logic [COORD_WIDTH-1:0]      o_jac_rx,
    output logic [COORD_WIDTH-1:0]      o_jac_ry,
    output logic [COORD_WIDTH-1:0]      o_jac_rz,
    output logic                        o_invalid,
    output logic                        o_last
);

    localparam int CW = COORD_WIDTH;
    localparam int FB = FRAC_BITS;
    localparam int NW = (CW + FB > 2 * FB + 1) ? CW + FB : 2 * FB + 1;

    logic [CW-2:0]        r_focal_x, r_focal_y;
    logic signed [CW-1:0] r_center_x, r_center_y;
    logic                 r_row;
    logic                 en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= (CW - 1)'(320) << FB;
            r_focal_y  <= (CW - 1)'(360) << FB;
            r_center_x <= CW'(639) << (FB - 1);
            r_center_y <= CW'(479) << (FB - 1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                phj_pkg::CFG_FOCAL_X:  r_focal_x  <= i_cfg_data[CW-2:0];
                phj_pkg::CFG_FOCAL_Y:  r_focal_y  <= i_cfg_data[CW-2:0];
                phj_pkg::CFG_CENTER_X: r_center_x <= i_cfg_data;
                phj_pkg::CFG_CENTER_Y: r_center_y <= i_cfg_data;
            endcase
        end
    end

    phj_pkg::t_tag in_tag;
    logic [CW-1:0] mag_x, mag_y;

    always_comb begin
        in_tag.neg_x = i_point_x[CW-1];
        in_tag.neg_y = i_point_y[CW-1];
        in_tag.zbad  = i_point_z[CW-1] | (i_point_z == '0);
        mag_x = i_point_x[CW-1] ? -i_point_x : i_point_x;
        mag_y = i_point_y[CW-1] ? -i_point_y : i_point_y;
    end

    logic          div_valid;
    phj_pkg::t_tag div_tag;
    logic [CW-2:0] div_den;
    logic [NW-1:0] div_quo [phj_pkg::NLANE];
    logic [CW-2:0] div_rem [phj_pkg::NLANE];

    phj_div #(.CW(CW), .FB(FB)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_tag   (in_tag),
        .i_den   (i_point_z[CW-2:0]),
        .i_mag_x (mag_x),
        .i_mag_y (mag_y),
        .o_valid (div_valid),
        .o_tag   (div_tag),
        .o_den   (div_den),
        .o_quo   (div_quo),
        .o_rem   (div_rem)
    );

    logic          res_valid;
    logic [CW-1:0] row0 [phj_pkg::NJ];
    logic [CW-1:0] row1 [phj_pkg::NJ];
    logic          bad0, bad1;

    phj_mul #(.CW(CW), .FB(FB)) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (div_valid),
        .i_tag      (div_tag),
        .i_den      (div_den),
        .i_quo      (div_quo),
        .i_rem      (div_rem),
        .i_focal_x  (r_focal_x),
        .i_focal_y  (r_focal_y),
        .i_center_x (r_center_x),
        .i_center_y (r_center_y),
        .o_valid    (res_valid),
        .o_row0     (row0),
        .o_row1     (row1),
        .o_bad0     (bad0),
        .o_bad1     (bad1)
    );

    // the whole pipeline moves while no finished item waits, or once the finished item has sent its second row
    assign en      = !res_valid || (!i_stall && r_row);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= 1'b0;
        end else if (res_valid && !i_stall) begin
            r_row <= !r_row;
        end
    end

    assign o_valid       = res_valid;
    assign o_row_index   = r_row;
    assign o_last        = r_row;
    assign o_pixel_coord = r_row ? row1[phj_pkg::J_PIX] : row0[phj_pkg::J_PIX];
    assign o_jac_tx      = r_row ? row1[phj_pkg::J_TX]  : row0[phj_pkg::J_TX];
    assign o_jac_ty      = r_row ? row1[phj_pkg::J_TY]  : row0[phj_pkg::J_TY];
    assign o_jac_tz      = r_row ? row1[phj_pkg::J_TZ]  : row0[phj_pkg::J_TZ];
    assign o_jac_rx      = r_row ? row1[phj_pkg::J_RX]  : row0[phj_pkg::J_RX];
    assign o_jac_ry      = r_row ? row1[phj_pkg::J_RY]  : row0[phj_pkg::J_RY];
    assign o_jac_rz      = r_row ? row1[phj_pkg::J_RZ]  : row0[phj_pkg::J_RZ];
    assign o_invalid     = r_row ? bad1 : bad0;

endmodule
`default_nettype wire
